// ----- sv/u16u8_pkg.sv -----
// ----------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and utf-8 encoding helpers for the transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] HIGH_SURR_MIN = 16'hd800;
   localparam logic [15:0] HIGH_SURR_MAX = 16'hdbff;
   localparam logic [15:0] LOW_SURR_MIN  = 16'hdc00;
   localparam logic [15:0] LOW_SURR_MAX  = 16'hdfff;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;
   localparam logic [20:0] CP_MAX_1B     = 21'h7f;
   localparam logic [20:0] CP_MAX_2B     = 21'h7ff;
   localparam logic [20:0] CP_MAX_3B     = 21'hffff;
   localparam logic [7:0]  LEAD_2B       = 8'hc0;
   localparam logic [7:0]  LEAD_3B       = 8'he0;
   localparam logic [7:0]  LEAD_4B       = 8'hf0;
   localparam logic [7:0]  CONT_BYTE     = 8'h80;
   localparam logic [5:0]  CONT_MASK     = 6'h3f;
   // top six bits shared by every high surrogate
   localparam logic [5:0]  HIGH_SURR_TAG = HIGH_SURR_MIN[15:10];

   // work handed from the front end to the back end
   typedef struct packed {
      logic [20:0] cp0;     // first code point (held high, pair or unit)
      logic [15:0] cp1;     // second code point (current unit after a held high)
      logic [1:0]  ncodes;  // code points present, 0 to 2
      logic        fin;     // string ends on this item
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp <= CP_MAX_1B) begin
         len = 3'd1;
      end else if (cp <= CP_MAX_2B) begin
         len = 3'd2;
      end else if (cp <= CP_MAX_3B) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] k);
      logic [7:0] b;
      logic [7:0] c0;
      logic [7:0] c6;
      logic [7:0] c12;
      c0  = CONT_BYTE | {2'b00, cp[5:0] & CONT_MASK};
      c6  = CONT_BYTE | {2'b00, cp[11:6] & CONT_MASK};
      c12 = CONT_BYTE | {2'b00, cp[17:12] & CONT_MASK};
      case (utf8_len(cp))
         3'd1: begin
            b = {1'b0, cp[6:0]};
         end
         3'd2: begin
            b = (k == 2'd0) ? (LEAD_2B | {3'b000, cp[10:6]}) : c0;
         end
         3'd3: begin
            case (k)
               2'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
               2'd1:    b = c6;
               default: b = c0;
            endcase
         end
         default: begin
            case (k)
               2'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
               2'd1:    b = c12;
               2'd2:    b = c6;
               default: b = c0;
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

// ----- sv/u16u8_req_if.sv -----
// ----------------------------------------------------------------------------
// u16u8_req_if
// code unit channel: valid/ready with one utf-16 unit per item
// ----------------------------------------------------------------------------
interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        end_of_buffer;

   modport source (output valid, output code_unit, output end_of_buffer, input ready);
   modport sink   (input valid, input code_unit, input end_of_buffer, output ready);
endinterface

// ----- sv/u16u8_rsp_if.sv -----
// ----------------------------------------------------------------------------
// u16u8_rsp_if
// byte channel: valid/ready with one utf-8 byte or end marker per item
// ----------------------------------------------------------------------------
interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       string_end;

   modport source (output valid, output out_byte, output byte_valid, output string_end,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input string_end,
                   output ready);
endinterface

// ----- sv/utf16le_to_utf8_stream.sv -----
// ----------------------------------------------------------------------------
// utf16le_to_utf8_stream
// utf-16le code unit stream to utf-8 byte stream transcoder
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  req_ch    in         valid / ready    code_unit[15:0], end_of_buffer
//  rsp_ch    out        valid / ready    out_byte[7:0], byte_valid, string_end
//  csr       in         csr_wr_en        csr_wr_data[15:0] -> max_units
//
//  one result item leaves per cycle from the output register unless stalled;
//  a unit gives 1 to 3 bytes (its utf-8 length), a surrogate pair 4, a flushed
//  high plus a unit up to 6, an empty string end a marker, a held high none
//  the front end takes a unit every cycle while the 4-entry job queue has room
//  synchronous reset clears surrogate, count and discard state, the queue and
//  the output valid; max_units resets to 65535
//  a stalled rsp_ch only holds the back end; the front keeps taking units
//  until the queue fills, then drops req_ch.ready
// ----------------------------------------------------------------------------
module utf16le_to_utf8_stream (
   input  logic        clock,
   input  logic        reset,
   u16u8_req_if.sink   req_ch,
   u16u8_rsp_if.source rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // configured unit limit per string
   logic [15:0] max_units_ff;

   logic                        push;
   logic                        pop;
   u16u8_pkg::job_type          push_job;
   u16u8_pkg::job_type          head_job;
   u16u8_pkg::queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_units_ff <= 16'hffff;
      end else if (csr_wr_en) begin
         max_units_ff <= csr_wr_data;
      end
   end

   // front: classify units, pair surrogates, count toward the limit
   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .max_units (max_units_ff),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // decoupling queue of pending code point jobs
   u16u8_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // back: serialize code points into utf-8 bytes and end markers
   u16u8_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

// ----- sv/u16u8_front.sv -----
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, tracks surrogates and string limits, emits jobs
// ----------------------------------------------------------------------------
module u16u8_front (
   input  logic                        clock,
   input  logic                        reset,
   u16u8_req_if.sink                   req,
   input  logic [15:0]                 max_units,
   input  u16u8_pkg::queue_status_type q_status,
   output logic                        push,
   output u16u8_pkg::job_type          push_job
);

   logic [9:0]  held_bits_ff, held_bits_in;
   logic        held_valid_ff, held_valid_in;
   logic [15:0] units_seen_ff, units_seen_in;
   logic        discarding_ff, discarding_in;

   logic accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && !q_status.full;

   always_comb begin
      logic [15:0] cu;
      logic        eob;
      logic [15:0] units_inc;
      logic        is_high;
      logic        is_low;
      logic [20:0] held_cp;
      cu        = req.code_unit;
      eob       = req.end_of_buffer;
      units_inc = units_seen_ff + 16'd1;
      is_high   = (cu >= u16u8_pkg::HIGH_SURR_MIN) && (cu <= u16u8_pkg::HIGH_SURR_MAX);
      is_low    = (cu >= u16u8_pkg::LOW_SURR_MIN) && (cu <= u16u8_pkg::LOW_SURR_MAX);
      held_cp   = {5'b00000, u16u8_pkg::HIGH_SURR_TAG, held_bits_ff};

      held_bits_in  = held_bits_ff;
      held_valid_in = held_valid_ff;
      units_seen_in = units_seen_ff;
      discarding_in = discarding_ff;
      push          = 1'b0;
      push_job      = '0;

      if (accept) begin
         if (discarding_ff) begin
            if (eob) begin
               held_valid_in = 1'b0;
               units_seen_in = '0;
               discarding_in = 1'b0;
            end
         end else if (units_seen_ff >= max_units) begin
            // unit not consumed: flush any held high and close the string
            push            = 1'b1;
            push_job.cp0    = held_cp;
            push_job.ncodes = held_valid_ff ? 2'd1 : 2'd0;
            push_job.fin    = 1'b1;
            held_valid_in   = 1'b0;
         end else begin
            units_seen_in = units_inc;
            held_valid_in = 1'b0;
            if (held_valid_ff && is_low) begin
               push            = 1'b1;
               push_job.cp0    = u16u8_pkg::SUPP_BASE + {1'b0, held_bits_ff, cu[9:0]};
               push_job.ncodes = 2'd1;
               push_job.fin    = eob || (units_inc >= max_units);
            end else begin
               push_job.cp0 = held_cp;
               if (cu == 16'd0) begin
                  push            = 1'b1;
                  push_job.ncodes = held_valid_ff ? 2'd1 : 2'd0;
                  push_job.fin    = 1'b1;
               end else if (is_high && !eob && (units_inc < max_units)) begin
                  held_bits_in    = cu[9:0];
                  held_valid_in   = 1'b1;
                  push            = held_valid_ff;
                  push_job.ncodes = held_valid_ff ? 2'd1 : 2'd0;
               end else begin
                  push = 1'b1;
                  if (held_valid_ff) begin
                     push_job.cp1    = cu;
                     push_job.ncodes = 2'd2;
                  end else begin
                     push_job.cp0    = {5'b00000, cu};
                     push_job.ncodes = 2'd1;
                  end
                  push_job.fin = eob || (units_inc >= max_units);
               end
            end
         end

         if (push && push_job.fin) begin
            held_valid_in = 1'b0;
            if (eob) begin
               units_seen_in = '0;
               discarding_in = 1'b0;
            end else begin
               discarding_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      held_bits_ff <= held_bits_in;
      if (reset) begin
         held_valid_ff <= 1'b0;
         units_seen_ff <= '0;
         discarding_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         units_seen_ff <= units_seen_in;
         discarding_ff <= discarding_in;
      end
   end

endmodule

// ----- sv/u16u8_queue.sv -----
// ----------------------------------------------------------------------------
// u16u8_queue
// short job fifo between front and back end
// ----------------------------------------------------------------------------
module u16u8_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  u16u8_pkg::job_type          push_job,
   input  logic                        pop,
   output u16u8_pkg::job_type          head_job,
   output u16u8_pkg::queue_status_type q_status
);

   u16u8_pkg::job_type                     slot_ff [u16u8_pkg::QUEUE_DEPTH];
   logic [u16u8_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [u16u8_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [u16u8_pkg::QCNT_W-1:0]           count_ff, count_in;

   localparam logic [u16u8_pkg::QCNT_W-1:0] DEPTH_CNT =
      u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH);
   localparam logic [u16u8_pkg::QPTR_W-1:0] LAST_PTR =
      u16u8_pkg::QPTR_W'(u16u8_pkg::QUEUE_DEPTH - 1);

   logic do_push;
   logic do_pop;

   assign q_status.full  = (count_ff == DEPTH_CNT);
   assign q_status.empty = (count_ff == '0);
   assign head_job       = slot_ff[rd_ptr_ff];
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/u16u8_back.sv -----
// ----------------------------------------------------------------------------
// u16u8_back
// walks each job one utf-8 byte or marker per cycle when not stalled
// ----------------------------------------------------------------------------
module u16u8_back (
   input  logic                        clock,
   input  logic                        reset,
   input  u16u8_pkg::job_type          head_job,
   input  u16u8_pkg::queue_status_type q_status,
   output logic                        pop,
   u16u8_rsp_if.source                 rsp
);

   logic       slot_ff, slot_in;
   logic [1:0] bidx_ff, bidx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       string_end_ff, string_end_in;

   logic advance;

   assign advance = !q_status.empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      logic [20:0] code;
      logic [2:0]  len;
      logic        last_byte;
      logic        last_code;
      code      = slot_ff ? {5'b00000, head_job.cp1} : head_job.cp0;
      len       = u16u8_pkg::utf8_len(code);
      last_byte = ({1'b0, bidx_ff} == (len - 3'd1));
      last_code = slot_ff || (head_job.ncodes == 2'd1);

      slot_in       = slot_ff;
      bidx_in       = bidx_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      string_end_in = string_end_ff;
      pop           = 1'b0;

      if (advance) begin
         rsp_valid_in = 1'b1;
         if (head_job.ncodes == 2'd0) begin
            // bare end marker
            out_byte_in   = '0;
            byte_valid_in = 1'b0;
            string_end_in = 1'b1;
            pop           = 1'b1;
         end else begin
            out_byte_in   = u16u8_pkg::utf8_byte(code, bidx_ff);
            byte_valid_in = 1'b1;
            string_end_in = head_job.fin && last_byte && last_code;
            if (last_byte) begin
               bidx_in = '0;
               if (last_code) begin
                  slot_in = 1'b0;
                  pop     = 1'b1;
               end else begin
                  slot_in = 1'b1;
               end
            end else begin
               bidx_in = bidx_ff + 2'd1;
            end
         end
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      string_end_ff <= string_end_in;
      if (reset) begin
         slot_ff      <= 1'b0;
         bidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         bidx_ff      <= bidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = out_byte_ff;
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.string_end = string_end_ff;

endmodule

// ----- sv/u16u8_checker.sv -----
// ----------------------------------------------------------------------------
// u16u8_checker
// port level checks on the byte output of the transcoder
// ----------------------------------------------------------------------------
module u16u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_string_end
);

   // output is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_byte_valid)
          && $stable(rsp_string_end)))
      else $error("stalled output item changed");

   // a bare marker always ends a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> (rsp_string_end && rsp_out_byte == 8'h00))
      else $error("bare marker without string end");

   // a multibyte lead byte is never the last byte of a string
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_valid && rsp_out_byte[7:6] == 2'b11) |-> !rsp_string_end)
      else $error("string ended on a lead byte");

endmodule

bind utf16le_to_utf8_stream u16u8_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_byte   (rsp_ch.out_byte),
   .rsp_byte_valid (rsp_ch.byte_valid),
   .rsp_string_end (rsp_ch.string_end)
);
